/* sv/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Sizes, beat types and the token that travels down the chain of level cells.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY    = 64;
   localparam int KEY_BITS    = 16;
   localparam int IN_KEY_BITS = 16;
   localparam int SYM_BITS    = 8;
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
   localparam int LEVELS      = COUNT_BITS;
   localparam int LVL_BITS    = $clog2(LEVELS);
   localparam int SLOT_BITS   = COUNT_BITS + 1;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                 req_type;
      logic [IN_KEY_BITS-1:0] key;
      logic [SYM_BITS-1:0]    symbol;
   } req_beat_type;

   typedef struct packed {
      status_type             status;
      logic [IN_KEY_BITS-1:0] out_key;
      logic [SYM_BITS-1:0]    out_symbol;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_beat_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [SYM_BITS-1:0] symbol;
   } entry_type;

   typedef struct packed {
      logic                  valid;
      op_type                op;
      logic [COUNT_BITS-1:0] slot;
      logic [COUNT_BITS-1:0] target;
      logic [COUNT_BITS-1:0] route;
      logic                  placed;
      entry_type             carry;
   } token_type;

   typedef struct packed {
      logic                 valid;
      logic [SLOT_BITS-1:0] slot;
   } child_req_type;

   typedef struct packed {
      token_type     tok;
      child_req_type req;
   } down_type;

   typedef struct packed {
      logic                 we;
      logic [SLOT_BITS-1:0] waddr;
      entry_type            wdata;
      logic [SLOT_BITS-1:0] raddr_a;
      logic [SLOT_BITS-1:0] raddr_b;
   } ram_ctl_type;

   function automatic int level_addr_bits(input int lvl);
      int span;
      int need;
      int ab;
      span = 1 << lvl;
      need = ((CAPACITY + 1 - span) < span) ? (CAPACITY + 1 - span) : span;
      ab   = $clog2(need);
      if (ab < 1) begin
         ab = 1;
      end
      return ab;
   endfunction

   function automatic logic [LVL_BITS-1:0] slot_level(input logic [COUNT_BITS-1:0] s);
      logic [LVL_BITS-1:0] lvl;
      lvl = '0;
      for (int i = 0; i < COUNT_BITS; i++) begin
         if (s[i]) begin
            lvl = LVL_BITS'(i);
         end
      end
      return lvl;
   endfunction

endpackage

/* sv/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// Heap level storage
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int ADDR_BITS = 1,
   parameter int WIDTH     = 8
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr_a,
   input  logic [ADDR_BITS-1:0] raddr_b,
   output logic [WIDTH-1:0]     rdata_a,
   output logic [WIDTH-1:0]     rdata_b
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_a_ff <= mem[raddr_a];
      rd_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;

endmodule

/* sv/mhpq_cell.sv */
// ----------------------------------------------------------------------------
// Heap level cell
// Holds the sift token for one heap level, decides the swap for that level,
// writes the level storage and hands the token to the next level.
// ----------------------------------------------------------------------------
module mhpq_cell import mhpq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  down_type              up,
   input  logic [COUNT_BITS-1:0] fetch_slot,
   input  logic [COUNT_BITS-1:0] fill,
   input  entry_type             own_a,
   input  entry_type             child_a,
   input  entry_type             child_b,
   output down_type              down,
   output ram_ctl_type           ram,
   output logic                  done
);

   token_type            tok_ff;
   token_type            tok_in;
   logic                 rdy_ff;
   logic                 rdy_in;
   logic                 act;
   logic [SLOT_BITS-1:0] lslot;
   logic [SLOT_BITS-1:0] rslot;
   logic [SLOT_BITS-1:0] fill_ext;
   logic                 left_ok;
   logic                 right_ok;
   logic                 pick_right;
   entry_type            pick;
   logic                 final_slot;
   logic                 swap;

   always_comb begin
      tok_in = tok_ff;
      rdy_in = rdy_ff;
      if (up.tok.valid) begin
         tok_in = up.tok;
         rdy_in = 1'b0;
      end else if (tok_ff.valid && !rdy_ff) begin
         rdy_in = 1'b1;
      end else if (tok_ff.valid) begin
         tok_in.valid = 1'b0;
         rdy_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         rdy_ff       <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         rdy_ff <= rdy_in;
      end
   end

   always_comb begin
      act        = tok_ff.valid && rdy_ff;
      lslot      = {tok_ff.slot, 1'b0};
      rslot      = {tok_ff.slot, 1'b1};
      fill_ext   = {1'b0, fill};
      left_ok    = lslot <= fill_ext;
      right_ok   = rslot <= fill_ext;
      pick_right = right_ok && (child_b.key > child_a.key);
      pick       = pick_right ? child_b : child_a;
      final_slot = tok_ff.slot == tok_ff.target;
      swap       = tok_ff.placed || (own_a.key < tok_ff.carry.key);

      down.tok       = tok_ff;
      down.tok.valid = 1'b0;
      down.req.valid = tok_ff.valid && !rdy_ff && (tok_ff.op == OP_DELETE);
      down.req.slot  = lslot;

      ram.we      = 1'b0;
      ram.waddr   = {1'b0, tok_ff.slot};
      ram.wdata   = tok_ff.carry;
      ram.raddr_a = {1'b0, fetch_slot};
      ram.raddr_b = up.req.slot | SLOT_BITS'(1);
      if (tok_ff.valid && (tok_ff.op == OP_INSERT)) begin
         ram.raddr_a = {1'b0, tok_ff.slot};
      end else if (up.req.valid) begin
         ram.raddr_a = up.req.slot;
      end

      done = 1'b0;

      if (act) begin
         if (tok_ff.op == OP_INSERT) begin
            if (final_slot) begin
               ram.we = 1'b1;
               done   = 1'b1;
            end else begin
               ram.we          = swap;
               down.tok.valid  = 1'b1;
               down.tok.slot   = {tok_ff.slot[COUNT_BITS-2:0], tok_ff.route[COUNT_BITS-1]};
               down.tok.route  = tok_ff.route << 1;
               down.tok.placed = swap;
               if (swap) begin
                  down.tok.carry = own_a;
               end
            end
         end else begin
            ram.we = 1'b1;
            if (left_ok && (pick.key > tok_ff.carry.key)) begin
               ram.wdata      = pick;
               down.tok.valid = 1'b1;
               down.tok.slot  = pick_right ? rslot[COUNT_BITS-1:0] : lslot[COUNT_BITS-1:0];
            end else begin
               done = 1'b1;
            end
         end
      end
   end

endmodule

/* sv/max_heap_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// Max-heap priority queue core
// An insert starts its sift at the root; a delete first fetches the root and
// the last entry, then sifts the last entry down from the root, with a read
// step and a decision step per heap level in the cell chain. A delete that
// empties the heap answers after the root fetch, without a sift. Rejected
// requests (full or empty) answer from the idle state. One request at a time;
// busy stays high until the result beat. Reset empties the heap at once and
// the storage is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core import mhpq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_beat_type req_data,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_beat_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH_ROOT,
      S_FETCH_LAST,
      S_LAST_DATA,
      S_SIFT
   } state_type;

   state_type             state_ff;
   logic [COUNT_BITS-1:0] fill_ff;
   token_type             issue_ff;
   entry_type             out_entry_ff;
   logic                  rsp_valid_ff;
   rsp_beat_type          rsp_ff;

   logic [COUNT_BITS-1:0] new_slot;
   logic [LVL_BITS-1:0]   new_lvl;
   logic [LVL_BITS:0]     shamt;
   logic [COUNT_BITS-1:0] new_route;
   logic [COUNT_BITS-1:0] fetch_slot;
   entry_type             last_entry;
   logic                  sift_done;

   down_type              down_chain [LEVELS+1];
   ram_ctl_type           ram_ctl    [LEVELS];
   entry_type             rd_a       [LEVELS];
   entry_type             rd_b       [LEVELS];
   logic [LEVELS-1:0]     done_vec;

   always_comb begin
      new_slot   = fill_ff + COUNT_BITS'(1);
      new_lvl    = slot_level(new_slot);
      shamt      = (LVL_BITS + 1)'(COUNT_BITS) - {1'b0, new_lvl};
      new_route  = new_slot << shamt;
      fetch_slot = (state_ff == S_FETCH_ROOT) ? COUNT_BITS'(1) : new_slot;
      last_entry = rd_a[new_lvl];
      sift_done  = (|done_vec) || down_chain[LEVELS].tok.valid;
   end

   assign down_chain[0].tok       = issue_ff;
   assign down_chain[0].req.valid = 1'b0;
   assign down_chain[0].req.slot  = '0;

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      localparam int AB = level_addr_bits(l);

      entry_type child_a;
      entry_type child_b;

      if (l < LEVELS - 1) begin : g_inner
         assign child_a = rd_a[l+1];
         assign child_b = rd_b[l+1];
      end else begin : g_leaf
         assign child_a = '0;
         assign child_b = '0;
      end

      mhpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up         (down_chain[l]),
         .fetch_slot (fetch_slot),
         .fill       (fill_ff),
         .own_a      (rd_a[l]),
         .child_a    (child_a),
         .child_b    (child_b),
         .down       (down_chain[l+1]),
         .ram        (ram_ctl[l]),
         .done       (done_vec[l])
      );

      mhpq_ram #(
         .ADDR_BITS (AB),
         .WIDTH     ($bits(entry_type))
      ) u_ram (
         .clock   (clock),
         .we      (ram_ctl[l].we),
         .waddr   (ram_ctl[l].waddr[AB-1:0]),
         .wdata   (ram_ctl[l].wdata),
         .raddr_a (ram_ctl[l].raddr_a[AB-1:0]),
         .raddr_b (ram_ctl[l].raddr_b[AB-1:0]),
         .rdata_a (rd_a[l]),
         .rdata_b (rd_b[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fill_ff        <= '0;
         issue_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         issue_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (req_data.req_type == OP_INSERT) begin
                     if (fill_ff >= COUNT_BITS'(CAPACITY)) begin
                        rsp_valid_ff       <= 1'b1;
                        rsp_ff.status      <= STATUS_FULL;
                        rsp_ff.out_key     <= '0;
                        rsp_ff.out_symbol  <= '0;
                        rsp_ff.entry_count <= fill_ff;
                     end else begin
                        issue_ff.valid        <= 1'b1;
                        issue_ff.op           <= OP_INSERT;
                        issue_ff.slot         <= COUNT_BITS'(1);
                        issue_ff.target       <= new_slot;
                        issue_ff.route        <= new_route;
                        issue_ff.placed       <= 1'b0;
                        issue_ff.carry.key    <= KEY_BITS'(req_data.key);
                        issue_ff.carry.symbol <= req_data.symbol;
                        fill_ff               <= new_slot;
                        out_entry_ff          <= '0;
                        state_ff              <= S_SIFT;
                     end
                  end else begin
                     if (fill_ff == '0) begin
                        rsp_valid_ff       <= 1'b1;
                        rsp_ff.status      <= STATUS_EMPTY;
                        rsp_ff.out_key     <= '0;
                        rsp_ff.out_symbol  <= '0;
                        rsp_ff.entry_count <= fill_ff;
                     end else begin
                        fill_ff  <= fill_ff - COUNT_BITS'(1);
                        state_ff <= S_FETCH_ROOT;
                     end
                  end
               end
            end
            S_FETCH_ROOT: begin
               state_ff <= S_FETCH_LAST;
            end
            S_FETCH_LAST: begin
               out_entry_ff <= rd_a[0];
               state_ff     <= S_LAST_DATA;
            end
            S_LAST_DATA: begin
               if (fill_ff == '0) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.status      <= STATUS_OK;
                  rsp_ff.out_key     <= IN_KEY_BITS'(out_entry_ff.key);
                  rsp_ff.out_symbol  <= out_entry_ff.symbol;
                  rsp_ff.entry_count <= fill_ff;
                  state_ff           <= S_IDLE;
               end else begin
                  issue_ff.valid  <= 1'b1;
                  issue_ff.op     <= OP_DELETE;
                  issue_ff.slot   <= COUNT_BITS'(1);
                  issue_ff.target <= '0;
                  issue_ff.route  <= '0;
                  issue_ff.placed <= 1'b0;
                  issue_ff.carry  <= last_entry;
                  state_ff        <= S_SIFT;
               end
            end
            S_SIFT: begin
               if (sift_done) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.status      <= STATUS_OK;
                  rsp_ff.out_key     <= IN_KEY_BITS'(out_entry_ff.key);
                  rsp_ff.out_symbol  <= out_entry_ff.symbol;
                  rsp_ff.entry_count <= fill_ff;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= COUNT_BITS'(CAPACITY))
      else $error("Entry count exceeds the heap capacity.");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("Accepted request neither answered nor in progress.");

   a_one_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0(done_vec))
      else $error("More than one level cell finished at once.");

   a_done_in_sift: assert property (@(posedge clock) disable iff (reset)
      (|done_vec) |-> (state_ff == S_SIFT))
      else $error("Level cell finished outside of a sift.");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_EMPTY)) |-> (rsp_data.entry_count == '0))
      else $error("Empty status with a nonzero entry count.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_FULL))
      |-> (rsp_data.entry_count == COUNT_BITS'(CAPACITY)))
      else $error("Full status below capacity.");
`endif

endmodule

/* tb/max_heap_priority_queue_core_tb.sv */
// ----------------------------------------------------------------------------
// Max-heap priority queue core testbench
// Drives insert and delete-max request beats in bursts with random gaps and
// keeps a shadow heap that predicts every result beat. The status, key,
// symbol and count of each result beat are compared with the oldest
// prediction. A short directed run covers the empty and tie cases. Random
// phases then fill the heap to its full state, drain it to empty and mix
// the two, using keys that are often tied or extreme.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core_tb;
   import mhpq_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BEATS = 1000;
   localparam int DRAIN_CYCLES = 40;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   class heap_shadow;
      logic [KEY_BITS-1:0] keys [CAPACITY];
      logic [SYM_BITS-1:0] syms [CAPACITY];
      int                  fill;
      int                  failures;
      rsp_beat_type        expected_beats [$];

      function new();
         fill     = 0;
         failures = 0;
      endfunction

      function void swap_slots(int a, int b);
         logic [KEY_BITS-1:0] tk;
         logic [SYM_BITS-1:0] ts;
         tk      = keys[a];
         ts      = syms[a];
         keys[a] = keys[b];
         syms[a] = syms[b];
         keys[b] = tk;
         syms[b] = ts;
      endfunction

      function rsp_beat_type predict_result(req_beat_type r);
         rsp_beat_type o;
         int           pos;
         int           parent;
         int           left;
         int           pick;
         o        = '0;
         o.status = STATUS_OK;
         if (r.req_type == OP_INSERT) begin
            if (fill >= CAPACITY) begin
               o.status = STATUS_FULL;
            end else begin
               keys[fill] = KEY_BITS'(r.key);
               syms[fill] = r.symbol;
               pos        = fill;
               fill++;
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (keys[parent] < keys[pos]) begin
                     swap_slots(parent, pos);
                     pos = parent;
                  end else begin
                     break;
                  end
               end
            end
         end else begin
            if (fill == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               o.out_key    = IN_KEY_BITS'(keys[0]);
               o.out_symbol = syms[0];
               fill--;
               keys[0] = keys[fill];
               syms[0] = syms[fill];
               pos     = 0;
               forever begin
                  left = 2 * pos + 1;
                  if (left >= fill) begin
                     break;
                  end
                  pick = left;
                  if (left + 1 < fill && keys[left + 1] > keys[left]) begin
                     pick = left + 1;
                  end
                  if (keys[pick] > keys[pos]) begin
                     swap_slots(pick, pos);
                     pos = pick;
                  end else begin
                     break;
                  end
               end
            end
         end
         o.entry_count = COUNT_BITS'(fill);
         return o;
      endfunction

      function void note_request(req_beat_type r);
         expected_beats = {expected_beats, predict_result(r)};
      endfunction

      function void log_failure(string what, rsp_beat_type want, rsp_beat_type got);
         if (failures < 10) begin
            $display({"%s: expected status %0d key %h symbol %h count %0d, ",
                      "got status %0d key %h symbol %h count %0d"},
                     what, want.status, want.out_key, want.out_symbol, want.entry_count,
                     got.status, got.out_key, got.out_symbol, got.entry_count);
         end
         failures++;
      endfunction

      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (expected_beats.size() == 0) begin
            want = '0;
            log_failure("unexpected result beat", want, got);
            return;
         end
         want = expected_beats.pop_front();
         if (got.status !== want.status || got.out_key !== want.out_key ||
             got.out_symbol !== want.out_symbol || got.entry_count !== want.entry_count) begin
            log_failure("result mismatch", want, got);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   req_beat_type req_data;
   logic         busy;
   logic         rsp_valid;
   rsp_beat_type rsp_data;

   heap_shadow   sb;
   int           cycle_count;

   max_heap_priority_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            sb.check_result(rsp_data);
         end
         if (start && !busy) begin
            sb.note_request(req_data);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("max_heap_priority_queue_core_tb: errors");
      $finish;
   end

   function automatic req_beat_type make_beat(op_type op, int key, int symbol);
      req_beat_type b;
      b.req_type = op;
      b.key      = IN_KEY_BITS'(key);
      b.symbol   = SYM_BITS'(symbol);
      return b;
   endfunction

   function automatic req_beat_type random_beat(mix_type mix);
      int     roll;
      int     key;
      op_type op;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  op = (roll < 85) ? OP_INSERT : OP_DELETE;
         MIX_DRAIN: op = (roll < 20) ? OP_INSERT : OP_DELETE;
         default:   op = (roll < 50) ? OP_INSERT : OP_DELETE;
      endcase
      case ($urandom_range(0, 3))
         0:       key = $urandom_range(0, 3);
         1:       key = $urandom_range(0, 1) ? 16'hFFFF - $urandom_range(0, 1) : $urandom_range(0, 1);
         default: key = $urandom_range(0, 16'hFFFF);
      endcase
      return make_beat(op, key, $urandom_range(0, 255));
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input req_beat_type beat);
      req_data = beat;
      start    = 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      logic [31:0] noise;
      noise    = $urandom();
      start    = 1'b0;
      req_data = noise[$bits(req_beat_type)-1:0];
      repeat (n) @(negedge clock);
   endtask

   initial begin
      req_beat_type directed [$];
      mix_type      mix;
      int           sent;
      int           phase_left;
      int           burst;
      int           gap;
      int           total_fail;

      sb       = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      idle_cycles(3);

      directed = {directed, make_beat(OP_DELETE, 16'h1234, 8'h56)};
      directed = {directed, make_beat(OP_INSERT, 16'h0000, 8'h00)};
      directed = {directed, make_beat(OP_INSERT, 16'hFFFF, 8'hFF)};
      directed = {directed, make_beat(OP_INSERT, 16'h0005, 8'h01)};
      directed = {directed, make_beat(OP_INSERT, 16'h0005, 8'h02)};
      directed = {directed, make_beat(OP_INSERT, 16'h0005, 8'h03)};
      directed = {directed, make_beat(OP_INSERT, 16'hFFFF, 8'hAA)};
      directed = {directed, make_beat(OP_INSERT, 16'hAAAA, 8'h55)};
      directed = {directed, make_beat(OP_INSERT, 16'h5555, 8'hAA)};
      for (int i = 0; i < 9; i++) begin
         directed = {directed, make_beat(OP_DELETE, 16'hFFFF, 8'hFF)};
      end
      directed = {directed, make_beat(OP_DELETE, 16'h0000, 8'h00)};
      for (int i = 0; i < directed.size(); i++) begin
         send_beat(directed[i]);
         if (i % 4 == 3) begin
            idle_cycles($urandom_range(1, 20));
         end
      end
      idle_cycles(2);

      mix        = MIX_FILL;
      phase_left = 120;
      sent       = 0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < RANDOM_BEATS; i++) begin
            if (phase_left == 0) begin
               case ($urandom_range(0, 2))
                  0:       mix = MIX_FILL;
                  1:       mix = MIX_DRAIN;
                  default: mix = MIX_EVEN;
               endcase
               phase_left = $urandom_range(60, 180);
            end
            send_beat(random_beat(mix));
            phase_left--;
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            idle_cycles(gap);
         end
      end
      idle_cycles(1);

      while (sb.expected_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      total_fail = sb.failures + sb.expected_beats.size();
      if (total_fail == 0) begin
         $display("max_heap_priority_queue_core_tb: clean");
      end else begin
         $display("max_heap_priority_queue_core_tb: errors");
      end
      $finish;
   end

endmodule
